/* rtl/dds_pkg.sv */
// Shared constants, types and the quarter-wave sine ROM of the multiwave oscillator.
package dds_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_WIDTH     = 16;

  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH  = SINE_TABLE_DEPTH / 4;
  localparam int QTR_IDX_W  = SINE_IDX_W - 2;

  // Waveform value before gain: holds +/-2S for the unclamped polluted sum
  localparam int VAL_W   = SAMPLE_WIDTH + 2;
  localparam int PROD_W  = VAL_W + 15;
  localparam int GPROD_W = VAL_W + 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SAW      = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_NOISE    = 3'd4;

  localparam int         CFG_IDX_W     = 2;
  localparam logic [1:0] REG_PHASE_INC = 2'd0;
  localparam logic [1:0] REG_WAVEFORM  = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;
  localparam logic [1:0] REG_POLLUTION = 2'd3;

  localparam logic [14:0] GAIN_RESET = 15'd16384;

  typedef struct packed {
    logic [31:0] phase_increment;
    logic [2:0]  waveform;
    logic [14:0] gain;
    logic [14:0] pollution;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              wave;
    logic [31:0]             phase;
    logic [SAMPLE_WIDTH-1:0] noise;
    logic                    pol_en;
  } qent_t;

  typedef logic [SAMPLE_WIDTH-2:0] qsin_rom_t [QTR_DEPTH];

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] QSIN_DIV  = 64'(2 * SINE_TABLE_DEPTH);
  localparam logic [63:0] SINE_FULL = 64'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

  // sin((pi/2) * m / depth) in Q30, degree-13 Taylor with truncating steps
  function automatic logic [63:0] quarter_sin(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (PI_Q30 * m) / QSIN_DIV;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    t  = (x * t) >> 30;
    if (t > ONE_Q30) begin
      t = ONE_Q30;
    end
    return t;
  endfunction

  function automatic logic [SAMPLE_WIDTH-2:0] sine_entry(input logic [63:0] m);
    logic [63:0] e;
    e = (quarter_sin(m) * SINE_FULL + (64'd1 << 29)) >> 30;
    return e[SAMPLE_WIDTH-2:0];
  endfunction

  function automatic qsin_rom_t build_qsin();
    qsin_rom_t rom;
    int        j;
    for (j = 0; j < QTR_DEPTH; j++) begin
      rom[j] = sine_entry(64'(4 * j));
    end
    return rom;
  endfunction

  localparam qsin_rom_t QSIN_ROM = build_qsin();
  // Magnitude at the quarter-wave peak, one entry past the end of the ROM
  localparam logic [SAMPLE_WIDTH-2:0] SINE_PEAK = sine_entry(64'(SINE_TABLE_DEPTH));

endpackage

/* rtl/dds_front.sv */
// Front end: accepts items, owns the phase accumulator and the noise LFSR.
module dds_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dds_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [31:0]                  in_phase_value,
  input  logic                         q_full,
  output logic                         q_push,
  output dds_pkg::qent_t               q_wdata
);

  logic [31:0] phase_acc_r;
  logic [31:0] phase_acc_nxt;
  logic [31:0] lfsr_r;
  logic [31:0] lfsr_nxt;
  logic [31:0] lfsr_step;
  logic        accept;
  logic        is_periodic;
  logic        is_noise;
  logic        draw;
  logic        pol_en;

  always_comb begin
    lfsr_step   = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? dds_pkg::LFSR_TAPS : 32'd0);
    is_periodic = cfg.waveform inside {[dds_pkg::WAVE_SINE:dds_pkg::WAVE_TRIANGLE]};
    is_noise    = (cfg.waveform == dds_pkg::WAVE_NOISE);
    pol_en      = is_periodic && (cfg.pollution != 15'd0);
    draw        = is_noise || pol_en;
    accept      = in_valid && !q_full;
    q_push      = accept && (in_opcode == dds_pkg::OP_SAMPLE);

    phase_acc_nxt = phase_acc_r;
    lfsr_nxt      = lfsr_r;
    if (accept) begin
      if (in_opcode == dds_pkg::OP_LOAD) begin
        phase_acc_nxt = in_phase_value;
      end else begin
        if (is_periodic) begin
          phase_acc_nxt = phase_acc_r + cfg.phase_increment;
        end
        if (draw) begin
          lfsr_nxt = lfsr_step;
        end
      end
    end

    q_wdata.wave   = cfg.waveform;
    q_wdata.phase  = phase_acc_r;
    q_wdata.noise  = lfsr_step[31 -: dds_pkg::SAMPLE_WIDTH];
    q_wdata.pol_en = pol_en;
  end

  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= 32'd0;
      lfsr_r      <= dds_pkg::LFSR_SEED;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      lfsr_r      <= lfsr_nxt;
    end
  end

endmodule

/* rtl/dds_queue.sv */
// Short FIFO that decouples the front end from the sample pipeline.
module dds_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dds_pkg::qent_t wdata,
  output logic           full,
  input  logic           pop,
  output dds_pkg::qent_t rdata,
  output logic           vld
);

  dds_pkg::qent_t                mem_r [dds_pkg::QUEUE_DEPTH];
  logic [dds_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [dds_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [dds_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [dds_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic [dds_pkg::QCNT_W-1:0]    cnt_r;
  logic [dds_pkg::QCNT_W-1:0]    cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [dds_pkg::QPTR_W-1:0] PTR_LAST = dds_pkg::QPTR_W'(dds_pkg::QUEUE_DEPTH - 1);
  localparam logic [dds_pkg::QCNT_W-1:0] CNT_FULL = dds_pkg::QCNT_W'(dds_pkg::QUEUE_DEPTH);

  always_comb begin
    full    = (cnt_r == CNT_FULL);
    vld     = (cnt_r != '0);
    rdata   = mem_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && vld;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/dds_back.sv */
// Back end: five-stage sample pipeline (shape, pollution, clamp, gain, saturate).
module dds_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dds_pkg::cfg_t                       cfg,
  input  logic                                q_vld,
  input  dds_pkg::qent_t                      q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dds_pkg::SAMPLE_WIDTH-1:0] out_sample
);

  localparam int W      = dds_pkg::SAMPLE_WIDTH;
  localparam int VAL_W  = dds_pkg::VAL_W;
  localparam int PROD_W = dds_pkg::PROD_W;
  localparam int GP_W   = dds_pkg::GPROD_W;
  localparam int RND_W  = GP_W - 14;

  localparam logic signed [VAL_W-1:0] S_POS   = VAL_W'(1 << (W - 1));
  localparam logic signed [VAL_W-1:0] S_NEG   = VAL_W'(-(1 << (W - 1)));
  localparam logic signed [VAL_W-1:0] THREE_S = VAL_W'(3 << (W - 1));
  localparam logic signed [GP_W-1:0]  ROUND   = GP_W'(8192);
  localparam logic signed [RND_W-1:0] SAT_HI  = RND_W'((1 << (W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO  = RND_W'(-(1 << (W - 1)));

  logic adv;

  // stage 1: waveform shape
  logic [dds_pkg::SINE_IDX_W-1:0] sidx;
  logic [dds_pkg::QTR_IDX_W-1:0]  low;
  logic [dds_pkg::QTR_IDX_W-1:0]  ridx;
  logic                           odd;
  logic                           neg;
  logic                           peak;
  logic [W-2:0]                   mag;
  logic signed [VAL_W-1:0]        sine_v;
  logic signed [W-1:0]            saw_w;
  logic [W:0]                     tri_u;
  logic signed [VAL_W-1:0]        tri_s;
  logic signed [W-1:0]            draw_w;
  logic signed [VAL_W-1:0]        s1_v_nxt;

  logic                           s1_vld_r;
  logic signed [VAL_W-1:0]        s1_v_r;
  logic signed [W-1:0]            s1_d_r;
  logic                           s1_pol_r;

  // stage 2: pollution product
  logic signed [15:0]             pol_s;
  logic signed [PROD_W-1:0]       s2_prod_nxt;
  logic                           s2_vld_r;
  logic signed [VAL_W-1:0]        s2_v_r;
  logic                           s2_pol_r;
  logic signed [PROD_W-1:0]       s2_prod_r;

  // stage 3: add and clamp
  logic signed [VAL_W-1:0]        pol_add;
  logic signed [VAL_W-1:0]        sum;
  logic signed [VAL_W-1:0]        s3_v_nxt;
  logic                           s3_vld_r;
  logic signed [VAL_W-1:0]        s3_v_r;

  // stage 4: gain product
  logic signed [15:0]             gain_s;
  logic signed [GP_W-1:0]         s4_m_nxt;
  logic                           s4_vld_r;
  logic signed [GP_W-1:0]         s4_m_r;

  // stage 5: round and saturate
  logic signed [GP_W-1:0]         rnd;
  logic signed [RND_W-1:0]        scaled;
  logic signed [W-1:0]            out_sample_nxt;
  logic                           out_valid_r;
  logic signed [W-1:0]            out_sample_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_vld;

  always_comb begin
    sidx   = q_rdata.phase[31 -: dds_pkg::SINE_IDX_W];
    neg    = sidx[dds_pkg::SINE_IDX_W-1];
    odd    = sidx[dds_pkg::SINE_IDX_W-2];
    low    = sidx[dds_pkg::QTR_IDX_W-1:0];
    ridx   = odd ? (dds_pkg::QTR_IDX_W'(0) - low) : low;
    peak   = odd && (low == '0);
    mag    = peak ? dds_pkg::SINE_PEAK : dds_pkg::QSIN_ROM[ridx];
    sine_v = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});

    saw_w  = $signed({~q_rdata.phase[31], q_rdata.phase[30 -: W-1]});
    tri_u  = q_rdata.phase[31 -: W+1];
    tri_s  = tri_u[W] ? (THREE_S - $signed({1'b0, tri_u})) : ($signed({1'b0, tri_u}) - S_POS);
    draw_w = $signed({~q_rdata.noise[W-1], q_rdata.noise[W-2:0]});

    case (q_rdata.wave)
      dds_pkg::WAVE_SINE:     s1_v_nxt = sine_v;
      dds_pkg::WAVE_SAW:      s1_v_nxt = {{2{saw_w[W-1]}}, saw_w};
      dds_pkg::WAVE_SQUARE: begin
        s1_v_nxt = ((q_rdata.phase != 32'd0) && !q_rdata.phase[31]) ? S_POS : S_NEG;
      end
      dds_pkg::WAVE_TRIANGLE: s1_v_nxt = tri_s;
      dds_pkg::WAVE_NOISE:    s1_v_nxt = {{2{draw_w[W-1]}}, draw_w};
      default:                s1_v_nxt = '0;
    endcase
  end

  always_comb begin
    pol_s       = $signed({1'b0, cfg.pollution});
    s2_prod_nxt = PROD_W'(pol_s) * PROD_W'(s1_d_r);

    // floor of the product over 2^15
    pol_add = $signed(s2_prod_r[PROD_W-1:15]);
    sum     = s2_v_r + pol_add;
    if (!s2_pol_r) begin
      s3_v_nxt = s2_v_r;
    end else if (sum < S_NEG) begin
      s3_v_nxt = S_NEG;
    end else if (sum > S_POS) begin
      s3_v_nxt = S_POS;
    end else begin
      s3_v_nxt = sum;
    end

    gain_s   = $signed({1'b0, cfg.gain});
    s4_m_nxt = GP_W'(s3_v_r) * GP_W'(gain_s);

    rnd    = s4_m_r + ROUND;
    scaled = $signed(rnd[GP_W-1:14]);
    if (scaled < SAT_LO) begin
      out_sample_nxt = SAT_LO[W-1:0];
    end else if (scaled > SAT_HI) begin
      out_sample_nxt = SAT_HI[W-1:0];
    end else begin
      out_sample_nxt = scaled[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= q_vld;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r       <= s1_v_nxt;
      s1_d_r       <= draw_w;
      s1_pol_r     <= q_rdata.pol_en;
      s2_v_r       <= s1_v_r;
      s2_pol_r     <= s1_pol_r;
      s2_prod_r    <= s2_prod_nxt;
      s3_v_r       <= s3_v_nxt;
      s4_m_r       <= s4_m_nxt;
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

/* rtl/multiwave_dds_oscillator.sv */
// Top level of the multiwave direct digital synthesis oscillator.
//
// Input channel (in_valid / in_stall, in_opcode, in_phase_value): an opcode
// of zero requests one sample, an opcode of one loads the phase accumulator
// and produces nothing. A transfer completes on a clock edge with valid high
// and stall low.
// Output channel (out_valid / out_stall, out_sample): one signed Q1.15
// sample per sample request, in request order.
// Configuration: cfg_we writes register cfg_index with cfg_wdata
// (0 phase increment, 1 waveform, 2 gain, 3 pollution); write only
// while no request is in flight.
// A taken sample request is written to the job queue and then passes the
// five back-end stages. One item per cycle is taken while in_stall is low;
// the phase add and the LFSR step in the front end are feedback loops.
// A stalled receiver freezes the five-stage back pipeline; the four-entry
// queue then fills and in_stall rises.
// Reset (rst_n low, synchronous): phase zero, LFSR at its seed, sine
// waveform, unity gain, no pollution, pipeline and queue empty.
module multiwave_dds_oscillator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [31:0]                             cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_opcode,
  input  logic [31:0]                             in_phase_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [dds_pkg::SAMPLE_WIDTH-1:0] out_sample
);

  dds_pkg::cfg_t  cfg_r;
  dds_pkg::cfg_t  cfg_nxt;
  dds_pkg::qent_t q_wdata;
  dds_pkg::qent_t q_rdata;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_vld;

  // Register file: decode the index, drop writes that hit no register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        dds_pkg::REG_PHASE_INC: cfg_nxt.phase_increment = cfg_wdata;
        dds_pkg::REG_WAVEFORM:  cfg_nxt.waveform        = cfg_wdata[2:0];
        dds_pkg::REG_GAIN:      cfg_nxt.gain            = cfg_wdata[14:0];
        dds_pkg::REG_POLLUTION: cfg_nxt.pollution       = cfg_wdata[14:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_increment <= 32'd0;
      cfg_r.waveform        <= dds_pkg::WAVE_SINE;
      cfg_r.gain            <= dds_pkg::GAIN_RESET;
      cfg_r.pollution       <= 15'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: take items, advance phase and noise state, queue sample jobs
  dds_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_phase_value (in_phase_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Hold sample jobs while the back end is stalled
  dds_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .vld   (q_vld)
  );

  // Back end: shape, pollute, clamp, apply gain, saturate
  dds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_vld      (q_vld),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  // A phase load never reaches the sample pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == dds_pkg::OP_LOAD) |-> !q_push)
    else $error("phase load queued as a sample job");

  // Every accepted sample request becomes a queued job
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == dds_pkg::OP_SAMPLE) |-> q_push)
    else $error("sample request lost in front end");

  // The back end pops only existing jobs
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_vld)
    else $error("pop from empty job queue");

  // A stalled output freezes the pipeline, so nothing leaves the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while output stalled");

endmodule
